// File: hdl/lps_pkg.sv
// lps_pkg: shared widths, register indexes, reset values and types of the
// laplacian sharpening core
// no dependencies
package lps_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int EW_W       = COL_W + 1;
  localparam int PIX_W      = 8;
  localparam int LINE_W     = 2 * PIX_W;
  localparam int CFG_W_W    = 12;
  localparam int CFG_H_W    = 16;
  localparam int STR_W      = 4;
  localparam int ROW_W      = CFG_H_W;
  localparam int CNT_W      = EW_W + ROW_W;
  localparam int PROD_W     = STR_W + PIX_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int RST_WIDTH    = 640;
  localparam int RST_HEIGHT   = 480;
  localparam int RST_STRENGTH = 5;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_STRENGTH     = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [PIX_W-1:0] north;
    logic [PIX_W-1:0] south;
    logic [PIX_W-1:0] west;
    logic [PIX_W-1:0] centre;
    logic [PIX_W-1:0] east;
  } window_t;

endpackage

// File: hdl/lps_ram.sv
// lps_ram: generic single write port, single read port ram with registered read
// no dependencies
module lps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/lps_kernel.sv
// lps_kernel: sharpening kernel on one window with clamp to pixel range; border forces 0
// depends on lps_pkg
module lps_kernel (
  input  lps_pkg::window_t                win_i,
  input  logic [lps_pkg::STR_W-1:0]       strength_i,
  input  logic                            border_i,
  output logic [lps_pkg::PIX_W-1:0]       pixel_o
);
  import lps_pkg::*;

  logic [PROD_W-1:0]       prod;
  logic signed [ACC_W-1:0] acc;

  always_comb begin
    prod = PROD_W'(strength_i) * PROD_W'(win_i.centre);
    acc  = $signed(ACC_W'(prod))
         - $signed(ACC_W'(win_i.north)) - $signed(ACC_W'(win_i.south))
         - $signed(ACC_W'(win_i.west))  - $signed(ACC_W'(win_i.east));
    priority if (border_i || acc < 0) begin
      pixel_o = '0;
    end else if (acc > $signed(ACC_W'((1 << PIX_W) - 1))) begin
      pixel_o = '1;
    end else begin
      pixel_o = acc[PIX_W-1:0];
    end
  end

endmodule

// File: hdl/laplacian_sharpen_3x3_core.sv
// laplacian_sharpen_3x3_core: 3x3 laplacian sharpening of a raster pixel stream
// depends on lps_pkg, lps_ram, lps_kernel
//
// usage
//   input channel (in_valid_i/in_ready_o): one request per pixel, kind_i = 0,
//   in raster order; after the frame, image_width+1 flush requests (kind_i = 1)
//   drain the remaining results. frame_last_o marks the last result of a frame.
//   output channel (out_valid_o/out_ready_i) carries pixel_out_o, frame_last_o.
//   results appear one line plus one pixel behind the pixels; border pixels
//   give 0. one request is taken every cycle while in_ready_o is high; a
//   result is registered. the line stores sit in one ram with a registered
//   read whose address runs one request ahead, so its data is ready in time.
//   if the receiver stalls, one more result is held in a skid register and
//   in_ready_o drops while it is full.
//   the cfg port (cfg_we_i, cfg_index_i, cfg_data_i) writes width, height and
//   strength; writes take effect for the next request.
//   reset returns the counters, window and registers to their defaults
//   (640 x 480, strength 5); the line stores are not cleared.
module laplacian_sharpen_3x3_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            kind_i,
  input  logic [lps_pkg::PIX_W-1:0]       pixel_in_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [lps_pkg::PIX_W-1:0]       pixel_out_o,
  output logic                            frame_last_o,
  input  logic                            cfg_we_i,
  input  logic [lps_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [lps_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import lps_pkg::*;

  // configuration
  logic [EW_W-1:0]   eff_w_q, eff_w_d;
  logic [ROW_W-1:0]  eff_h_q, eff_h_d;
  logic [STR_W-1:0]  strength_q, strength_d;
  logic [CNT_W-1:0]  total_q, total_d;
  logic [CFG_W_W-1:0] cfg_w;
  logic [CFG_H_W-1:0] cfg_h;

  // frame state
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [CNT_W-1:0]  emit_q, emit_d;
  logic [COL_W-1:0]  ocol_q, ocol_d;
  logic [ROW_W-1:0]  orow_q, orow_d;
  logic [PIX_W-1:0]  w2_q, w2_d, w4_q, w4_d, w5_q, w5_d, w8_q, w8_d;

  // line store
  logic [LINE_W-1:0] ram_rdata;
  logic [LINE_W-1:0] byp_data_q;
  logic              byp_q;
  logic [LINE_W-1:0] line;
  logic              ram_we;
  logic [PIX_W-1:0]  top_new, mid_new;

  // output stage
  logic              out_valid_q, out_valid_d, out_last_q;
  logic [PIX_W-1:0]  out_pix_q;
  logic              skid_valid_q, skid_valid_d, skid_last_q;
  logic [PIX_W-1:0]  skid_pix_q;
  logic              out_free;

  // item logic
  logic              accept, complete, pix_cond, is_pix, early, done;
  logic [EW_W-1:0]   col_inc, ocol_inc;
  logic              col_wrap, ocol_wrap;
  logic [CNT_W-1:0]  emit_inc;
  logic              border, res_valid, res_last, clear;
  logic [PIX_W-1:0]  kern_pix, res_pix;
  window_t           win;

  assign in_ready_o = !skid_valid_q;
  assign accept     = in_valid_i && in_ready_o;

  // configuration next values
  always_comb begin
    eff_w_d    = eff_w_q;
    eff_h_d    = eff_h_q;
    strength_d = strength_q;
    cfg_w      = cfg_data_i[CFG_W_W-1:0];
    cfg_h      = cfg_data_i[CFG_H_W-1:0];
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_IMAGE_WIDTH: begin
          priority if (cfg_w == '0) begin
            eff_w_d = EW_W'(1);
          end else if (32'(cfg_w) > 32'(MAX_WIDTH)) begin
            eff_w_d = EW_W'(MAX_WIDTH);
          end else begin
            eff_w_d = EW_W'(cfg_w);
          end
        end
        REG_IMAGE_HEIGHT: begin
          eff_h_d = (cfg_h == '0) ? ROW_W'(1) : cfg_h;
        end
        REG_STRENGTH: begin
          strength_d = cfg_data_i[STR_W-1:0];
        end
        default: begin
        end
      endcase
    end
    total_d = CNT_W'(eff_w_d) * CNT_W'(eff_h_d);
  end

  // line data with read-during-write forwarding
  assign line    = byp_q ? byp_data_q : ram_rdata;
  assign top_new = line[LINE_W-1:PIX_W];
  assign mid_new = line[PIX_W-1:0];

  assign complete = row_q >= eff_h_q;
  assign pix_cond = (kind_i == KIND_PIXEL) && !complete;
  assign is_pix   = accept && pix_cond;
  assign col_inc  = EW_W'(col_q) + EW_W'(1);
  assign col_wrap = col_inc >= eff_w_q;
  assign early    = (row_q == '0) ? (EW_W'(col_q) <= eff_w_q)
                                  : ((row_q == ROW_W'(1)) && (col_q == '0));
  assign done     = emit_q >= total_q;
  assign emit_inc = emit_q + CNT_W'(1);
  assign res_last = emit_inc >= total_q;
  assign ocol_inc = EW_W'(ocol_q) + EW_W'(1);
  assign ocol_wrap = ocol_inc >= eff_w_q;
  assign border   = (orow_q == '0) || (ocol_q == '0)
                 || ((ROW_W + 1)'(orow_q) + (ROW_W + 1)'(1) >= (ROW_W + 1)'(eff_h_q))
                 || ocol_wrap;

  assign res_valid = is_pix ? (!early && !done) : (accept && complete && !done);
  assign clear     = (res_valid && res_last) || (accept && complete && done);

  assign win.north  = w2_q;
  assign win.south  = w8_q;
  assign win.west   = w4_q;
  assign win.centre = w5_q;
  assign win.east   = mid_new;

  lps_kernel u_kernel (
    .win_i      (win),
    .strength_i (strength_q),
    .border_i   (border),
    .pixel_o    (kern_pix)
  );

  assign res_pix = is_pix ? kern_pix : '0;

  // frame state next values
  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    emit_d = emit_q;
    ocol_d = ocol_q;
    orow_d = orow_q;
    w2_d   = w2_q;
    w4_d   = w4_q;
    w5_d   = w5_q;
    w8_d   = w8_q;
    if (is_pix) begin
      w2_d = top_new;
      w4_d = w5_q;
      w5_d = mid_new;
      w8_d = pixel_in_i;
      if (col_wrap) begin
        col_d = '0;
        row_d = row_q + ROW_W'(1);
      end else begin
        col_d = col_inc[COL_W-1:0];
      end
    end
    if (res_valid) begin
      emit_d = emit_inc;
      if (ocol_wrap) begin
        ocol_d = '0;
        orow_d = orow_q + ROW_W'(1);
      end else begin
        ocol_d = ocol_inc[COL_W-1:0];
      end
    end
    if (clear) begin
      col_d  = '0;
      row_d  = '0;
      emit_d = '0;
      ocol_d = '0;
      orow_d = '0;
      w2_d   = '0;
      w4_d   = '0;
      w5_d   = '0;
      w8_d   = '0;
    end
  end

  assign ram_we = is_pix;

  lps_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (col_q),
    .wdata_i ({mid_new, pixel_in_i}),
    .raddr_i (col_d),
    .rdata_o (ram_rdata)
  );

  // output register and skid
  assign out_free     = !out_valid_q || out_ready_i;
  assign out_valid_d  = out_free ? (skid_valid_q || res_valid) : 1'b1;
  assign skid_valid_d = out_free ? 1'b0 : (skid_valid_q || res_valid);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_w_q      <= EW_W'(RST_WIDTH);
      eff_h_q      <= ROW_W'(RST_HEIGHT);
      strength_q   <= STR_W'(RST_STRENGTH);
      total_q      <= CNT_W'(RST_WIDTH * RST_HEIGHT);
      col_q        <= '0;
      row_q        <= '0;
      emit_q       <= '0;
      ocol_q       <= '0;
      orow_q       <= '0;
      w2_q         <= '0;
      w4_q         <= '0;
      w5_q         <= '0;
      w8_q         <= '0;
      byp_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      eff_w_q      <= eff_w_d;
      eff_h_q      <= eff_h_d;
      strength_q   <= strength_d;
      total_q      <= total_d;
      col_q        <= col_d;
      row_q        <= row_d;
      emit_q       <= emit_d;
      ocol_q       <= ocol_d;
      orow_q       <= orow_d;
      w2_q         <= w2_d;
      w4_q         <= w4_d;
      w5_q         <= w5_d;
      w8_q         <= w8_d;
      byp_q        <= ram_we && (col_q == col_d);
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= {mid_new, pixel_in_i};
    if (out_free) begin
      out_pix_q  <= skid_valid_q ? skid_pix_q : res_pix;
      out_last_q <= skid_valid_q ? skid_last_q : res_last;
    end
    if (!out_free && res_valid) begin
      skid_pix_q  <= res_pix;
      skid_last_q <= res_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_out_o  = out_pix_q;
  assign frame_last_o = out_last_q;

`ifndef SYNTH
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register full while output register empty");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_last) |=> (emit_q == '0 && row_q == '0 && col_q == '0))
    else $error("frame counters not cleared after last result");

  a_stall_to_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_free && res_valid) |=> skid_valid_q)
    else $error("result lost while output stalled");
`endif

endmodule

// File: test/laplacian_sharpen_3x3_core_tb.sv
`timescale 1ns / 1ps
// testbench for laplacian_sharpen_3x3_core: directed and random raster frames with flush tails,
// checked against a line-buffered sharpening tracker; depends on lps_pkg and the core
module laplacian_sharpen_3x3_core_tb;
  import lps_pkg::*;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int PHASE_ITEMS = 180;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic             last;
  } sharp_pixel_t;

  class sharpen_tracker;
    logic [CFG_W_W-1:0] width_reg;
    logic [CFG_H_W-1:0] height_reg;
    logic [STR_W-1:0]   strength_reg;
    logic [PIX_W-1:0]   older_line[MAX_WIDTH];
    logic [PIX_W-1:0]   newer_line[MAX_WIDTH];
    logic [PIX_W-1:0]   win[9];
    int unsigned        col;
    int unsigned        row;
    int unsigned        emitted;
    sharp_pixel_t       expected_pixels[$];
    int                 errors;

    function new();
      width_reg    = CFG_W_W'(RST_WIDTH);
      height_reg   = CFG_H_W'(RST_HEIGHT);
      strength_reg = STR_W'(RST_STRENGTH);
      foreach (older_line[k]) begin
        older_line[k] = '0;
        newer_line[k] = '0;
      end
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      foreach (win[k]) win[k] = '0;
      col     = 0;
      row     = 0;
      emitted = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_IMAGE_WIDTH:  width_reg = data[CFG_W_W-1:0];
        REG_IMAGE_HEIGHT: height_reg = data[CFG_H_W-1:0];
        REG_STRENGTH:     strength_reg = data[STR_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned frame_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned frame_height();
      return (height_reg == 0) ? 1 : height_reg;
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    function logic [PIX_W-1:0] sharpened(int unsigned w, int unsigned h);
      int unsigned r;
      int unsigned c;
      int          acc;
      r = emitted / w;
      c = emitted % w;
      if (r == 0 || c == 0 || r + 1 >= h || c + 1 >= w) return '0;
      acc = int'(strength_reg) * int'(win[4])
          - int'(win[1]) - int'(win[7]) - int'(win[3]) - int'(win[5]);
      if (acc < 0) acc = 0;
      if (acc > 255) acc = 255;
      return PIX_W'(acc);
    endfunction

    function void note_request(logic kind, logic [PIX_W-1:0] pix);
      int unsigned  w;
      int unsigned  h;
      int unsigned  total;
      int unsigned  idx;
      int unsigned  pos;
      bit           complete;
      logic [PIX_W-1:0] top;
      logic [PIX_W-1:0] mid;
      sharp_pixel_t res;
      w        = frame_width();
      h        = frame_height();
      total    = w * h;
      complete = row >= h;
      if (kind == KIND_PIXEL && !complete) begin
        idx = (col < MAX_WIDTH) ? col : MAX_WIDTH - 1;
        pos = row * w + col;
        top = older_line[idx];
        mid = newer_line[idx];
        older_line[idx] = mid;
        newer_line[idx] = pix;
        for (int k = 0; k < 3; k++) begin
          win[k*3]   = win[k*3+1];
          win[k*3+1] = win[k*3+2];
        end
        win[2] = top;
        win[5] = mid;
        win[8] = pix;
        col++;
        if (col >= w) begin
          col = 0;
          row++;
        end
        if (pos < w + 1 || emitted >= total) return;
        res.value = sharpened(w, h);
      end else begin
        // flush, or pixel arriving once the frame is in
        if (!complete) return;
        if (emitted >= total) begin
          clear_frame();
          return;
        end
        res.value = '0;
      end
      res.last = (emitted + 1 >= total);
      expected_pixels.push_back(res);
      emitted++;
      if (emitted >= total) clear_frame();
    endfunction

    function void check_output(logic [PIX_W-1:0] pix, logic last);
      sharp_pixel_t want;
      if (expected_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected result pixel_out=%0d frame_last=%0b", $time, pix, last);
        return;
      end
      want = expected_pixels.pop_front();
      if (pix !== want.value) begin
        errors++;
        $display("%0t: pixel_out expected %0d, got %0d", $time, want.value, pix);
      end
      if (last !== want.last) begin
        errors++;
        $display("%0t: frame_last expected %0b, got %0b", $time, want.last, last);
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic                  kind_i;
  logic [PIX_W-1:0]      pixel_in_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [PIX_W-1:0]      pixel_out_o;
  logic                  frame_last_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  sharpen_tracker track;
  int             send_idle_pct;
  int             recv_stall_pct;
  int unsigned    cycle_count;

  laplacian_sharpen_3x3_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .pixel_in_i   (pixel_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pixel_out_o  (pixel_out_o),
    .frame_last_o (frame_last_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) track.check_output(pixel_out_o, frame_last_o);
      if (in_valid_i && in_ready_o) track.note_request(kind_i, pixel_in_i);
    end
  end

  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  task automatic send_request(input logic kind, input logic [PIX_W-1:0] pix);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    pixel_in_i <= pix;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (track.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] w_data,
                           input logic [CFG_DATA_W-1:0] h_data,
                           input logic [CFG_DATA_W-1:0] s_data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_IMAGE_WIDTH;
    cfg_data_i  <= w_data;
    @(posedge clk_i);
    cfg_index_i <= REG_IMAGE_HEIGHT;
    cfg_data_i  <= h_data;
    @(posedge clk_i);
    cfg_index_i <= REG_STRENGTH;
    cfg_data_i  <= s_data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    track.write_reg(REG_IMAGE_WIDTH, w_data);
    track.write_reg(REG_IMAGE_HEIGHT, h_data);
    track.write_reg(REG_STRENGTH, s_data);
  endtask

  // whole frame plus flush tail; stray flushes inside the frame are ignored
  task automatic run_frame(input int noise_pct, input int alias_pct, output int n_items);
    int unsigned w;
    int unsigned h;
    int unsigned i;
    w = track.frame_width();
    h = track.frame_height();
    for (i = 0; i < w * h; i++) begin
      if ($urandom_range(99) < noise_pct) send_request(KIND_FLUSH, PIX_W'($urandom));
      send_request(KIND_PIXEL, pick_pixel());
    end
    for (i = 0; i <= w; i++) begin
      if ($urandom_range(99) < alias_pct) send_request(KIND_PIXEL, PIX_W'($urandom));
      else send_request(KIND_FLUSH, PIX_W'($urandom));
    end
    if ($urandom_range(9) == 0) send_request(KIND_FLUSH, PIX_W'($urandom));
    n_items = w * h + w + 1;
  endtask

  initial begin
    int                    phase;
    int                    n;
    int                    count;
    int                    i;
    logic [CFG_DATA_W-1:0] wd;
    logic [CFG_DATA_W-1:0] hd;
    logic [CFG_DATA_W-1:0] sd;
    track          = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cycle_count    = 0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    kind_i         = KIND_PIXEL;
    pixel_in_i     = '0;
    out_ready_i    = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = REG_IMAGE_WIDTH;
    cfg_data_i     = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // bright centre on black, saturates high
    configure(16'd3, 16'd3, 16'd10);
    send_request(KIND_FLUSH, 8'hA5);
    for (i = 0; i < 9; i++) send_request(KIND_PIXEL, (i == 4) ? 8'hFF : 8'h00);
    for (i = 0; i < 4; i++) send_request(KIND_FLUSH, 8'h5A);
    drain();

    // dark centre on white, saturates low; pause mid frame until all results are out
    configure(16'd3, 16'd3, 16'd1);
    for (i = 0; i < 9; i++) begin
      if (i == 5) drain();
      send_request(KIND_PIXEL, (i == 4) ? 8'h00 : 8'hFF);
    end
    send_request(KIND_PIXEL, 8'h3C);
    for (i = 0; i < 3; i++) send_request(KIND_FLUSH, 8'h00);
    drain();

    // register extremes
    configure(16'd0, 16'd0, 16'd0);
    run_frame(0, 0, n);
    drain();
    configure(16'hF004, 16'd3, 16'd15);
    run_frame(5, 5, n);
    drain();
    configure(16'd5, 16'd1, 16'd10);
    run_frame(0, 0, n);
    drain();
    configure(16'd1, 16'd6, 16'd1);
    run_frame(0, 0, n);
    drain();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      count = 0;
      while (count < PHASE_ITEMS) begin
        wd = ($urandom_range(7) == 0) ? CFG_DATA_W'($urandom_range(13, 40))
                                      : CFG_DATA_W'($urandom_range(1, 12));
        if ($urandom_range(3) == 0) wd[15:12] = 4'($urandom);
        hd = ($urandom_range(9) == 0) ? '0 : CFG_DATA_W'($urandom_range(1, 8));
        sd = ($urandom_range(3) == 0) ? CFG_DATA_W'($urandom_range(0, 15))
                                      : CFG_DATA_W'($urandom_range(1, 10));
        if ($urandom_range(3) == 0) sd[15:4] = 12'($urandom);
        configure(wd, hd, sd);
        run_frame(5, 10, n);
        count += n;
        drain();
      end
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    drain();
    repeat (20) @(posedge clk_i);
    if (track.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/lps_pkg.sv
hdl/lps_ram.sv
hdl/lps_kernel.sv
hdl/laplacian_sharpen_3x3_core.sv
test/laplacian_sharpen_3x3_core_tb.sv
